[rtl/core/cnmh_pkg.sv]
`timescale 1ns / 1ps

package cnmh_pkg;

   localparam logic [7:0] START_BYTE = 8'h2A;

   // message kinds
   localparam logic [7:0] KIND_ON         = 8'd0;
   localparam logic [7:0] KIND_OFF        = 8'd1;
   localparam logic [7:0] KIND_TOGGLE     = 8'd2;
   localparam logic [7:0] KIND_FLASH      = 8'd3;
   localparam logic [7:0] KIND_SEND_STATE = 8'd11;
   localparam logic [7:0] KIND_FEEDBACK   = 8'd12;
   localparam logic [7:0] KIND_TRIGGER    = 8'd13;

   // trigger extra codes
   localparam logic [7:0] TRIG_OFF   = 8'd0;
   localparam logic [7:0] TRIG_ON    = 8'd1;
   localparam logic [7:0] TRIG_FLASH = 8'd2;

   // lamp actions
   localparam logic [2:0] ACT_NONE   = 3'd0;
   localparam logic [2:0] ACT_ON     = 3'd1;
   localparam logic [2:0] ACT_OFF    = 3'd2;
   localparam logic [2:0] ACT_TOGGLE = 3'd3;
   localparam logic [2:0] ACT_FLASH  = 3'd4;

   // node state reset values
   localparam logic [7:0] NODE_ADDRESS_RST   = 8'd80;
   localparam logic [7:0] NET_HEADER_RST     = 8'd45;
   localparam logic [7:0] TRIGGER_SOURCE_RST = 8'd90;
   localparam logic [7:0] LAST_ID_RST        = 8'd0;

   typedef struct packed {
      logic [7:0] node_address;
      logic [7:0] net_header;
      logic [7:0] trigger_source;
      logic [7:0] last_id;
      logic       lamp;
   } node_state_type;

   typedef struct packed {
      logic [7:0] hdr;
      logic [7:0] id;
      logic [7:0] kind;
      logic [7:0] from;
      logic [7:0] to;
      logic [7:0] bounce;
      logic [7:0] extra;
   } frame_type;

   typedef struct packed {
      logic [2:0] action;
      logic       lamp;
      logic       reply_valid;
      logic [7:0] reply_header;
      logic [7:0] reply_id;
      logic [7:0] reply_from;
      logic [7:0] reply_to;
      logic [7:0] reply_extra;
   } result_type;

endpackage

[rtl/core/cnmh_channels.sv]
`timescale 1ns / 1ps

interface cnmh_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface cnmh_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] action;
   logic       lamp;
   logic       reply_valid;
   logic [7:0] reply_header;
   logic [7:0] reply_id;
   logic [7:0] reply_from;
   logic [7:0] reply_to;
   logic [7:0] reply_extra;

   modport source (output valid, output action, output lamp, output reply_valid,
                   output reply_header, output reply_id, output reply_from,
                   output reply_to, output reply_extra, input ready);
   modport sink (input valid, input action, input lamp, input reply_valid,
                 input reply_header, input reply_id, input reply_from,
                 input reply_to, input reply_extra, output ready);
endinterface

interface cnmh_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] reply_address;

   modport source (output valid, output reply_address, input ready);
   modport sink (input valid, input reply_address, output ready);
endinterface

[rtl/core/cnmh_decode.sv]
`timescale 1ns / 1ps

module cnmh_decode (
   input  cnmh_pkg::frame_type      frame,
   input  cnmh_pkg::node_state_type state_cur,
   input  logic [7:0]               reply_address,
   output cnmh_pkg::node_state_type state_nxt,
   output cnmh_pkg::result_type     result
);
   import cnmh_pkg::*;

   logic [2:0] act;
   logic       reply;
   logic [7:0] extra_out;
   logic       lamp_nxt;

   always_comb begin
      act       = ACT_NONE;
      reply     = 1'b0;
      extra_out = frame.extra;
      state_nxt = state_cur;

      if (frame.hdr == state_cur.net_header) begin
         state_nxt.last_id = frame.id;
         if (frame.to == state_cur.node_address) begin
            if (frame.id != state_cur.last_id) begin
               case (frame.kind)
                  KIND_TOGGLE: act = ACT_TOGGLE;
                  KIND_ON:     act = ACT_ON;
                  KIND_OFF:    act = ACT_OFF;
                  KIND_FLASH:  act = ACT_FLASH;
                  KIND_TRIGGER: begin
                     state_nxt.trigger_source = frame.extra;
                     act = ACT_FLASH;
                  end
                  KIND_FEEDBACK: begin
                     state_nxt.net_header   = frame.id;
                     state_nxt.node_address = frame.extra;
                     act = ACT_FLASH;
                  end
                  KIND_SEND_STATE: extra_out = {7'd0, state_cur.lamp};
                  default: act = ACT_NONE;
               endcase
               reply = (frame.kind != KIND_FEEDBACK);
            end
         end else if (frame.kind == KIND_TRIGGER &&
                      state_cur.trigger_source == frame.from) begin
            case (frame.extra)
               TRIG_OFF:   act = ACT_OFF;
               TRIG_ON:    act = ACT_ON;
               TRIG_FLASH: act = ACT_FLASH;
               default:    act = ACT_TOGGLE;
            endcase
         end
      end

      case (act)
         ACT_ON:     lamp_nxt = 1'b1;
         ACT_OFF:    lamp_nxt = 1'b0;
         ACT_FLASH:  lamp_nxt = 1'b0;
         ACT_TOGGLE: lamp_nxt = ~state_cur.lamp;
         default:    lamp_nxt = state_cur.lamp;
      endcase
      state_nxt.lamp = lamp_nxt;

      result.action       = act;
      result.lamp         = lamp_nxt;
      result.reply_valid  = reply;
      result.reply_header = reply ? state_nxt.net_header : 8'd0;
      result.reply_id     = reply ? frame.id : 8'd0;
      result.reply_from   = reply ? 8'(frame.from + frame.bounce) : 8'd0;
      result.reply_to     = reply ? reply_address : 8'd0;
      result.reply_extra  = reply ? extra_out : 8'd0;
   end

endmodule

[rtl/core/control_node_message_handler_top.sv]
`timescale 1ns / 1ps

// Control node message handler. Received serial bytes arrive one per item on
// req; while idle a '*' byte opens a frame and the next FRAME_BYTES bytes
// (header, id, kind, [pad], from, to, bounce, extra) form one message. The
// last byte of a frame produces exactly one item on rsp carrying the lamp
// action, the lamp level after it, and an optional feedback reply; all other
// bytes produce nothing. A byte is latched into an input register; once the
// result slot is free, the framer and message decode act on it there and
// load the result register, from which a frame's result is presented on rsp.
// The block takes one byte per cycle as long as rsp is not stalled; while a
// result waits on rsp, the byte in the input register is held and req takes
// nothing more until rsp drains. The reply_address register is written
// through csr, which is always ready, and should only be written while no
// frame is in flight.

module control_node_message_handler_top #(
   parameter int FRAME_BYTES = 7
) (
   input logic        clock,
   input logic        reset,
   cnmh_req_if.sink   req,
   cnmh_rsp_if.source rsp,
   cnmh_csr_if.sink   csr
);
   import cnmh_pkg::*;

   localparam int CW = $clog2(FRAME_BYTES);
   localparam int STORE_DEPTH = FRAME_BYTES - 1;
   localparam logic [CW-1:0] LAST_COUNT = CW'(FRAME_BYTES - 1);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;

   // framer state
   logic          in_frame_ff, in_frame_in;
   logic [CW-1:0] count_ff, count_in;
   logic [7:0]    store_ff [STORE_DEPTH];

   // node state and config
   node_state_type state_ff, state_nxt;
   logic [7:0]     reply_address_ff;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff, result;

   frame_type frame;
   logic      advance;
   logic      store_wr;
   logic      fire;

   // the byte in the input register moves on when the result slot is free
   assign advance  = in_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;

   assign store_wr = advance && in_frame_ff && (count_ff != LAST_COUNT);
   assign fire     = advance && in_frame_ff && (count_ff == LAST_COUNT);

   // the last byte of a frame is taken straight from the input register
   assign frame.hdr    = store_ff[0];
   assign frame.id     = store_ff[1];
   assign frame.kind   = store_ff[2];
   assign frame.from   = store_ff[FRAME_BYTES-4];
   assign frame.to     = store_ff[FRAME_BYTES-3];
   assign frame.bounce = store_ff[FRAME_BYTES-2];
   assign frame.extra  = in_byte_ff;

   cnmh_decode u_decode (
      .frame         (frame),
      .state_cur     (state_ff),
      .reply_address (reply_address_ff),
      .state_nxt     (state_nxt),
      .result        (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req.valid && req.ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // framer: hunt for the start byte, then count frame bytes
   always_comb begin
      in_frame_in = in_frame_ff;
      count_in    = count_ff;
      if (advance) begin
         if (!in_frame_ff) begin
            if (in_byte_ff == START_BYTE) begin
               in_frame_in = 1'b1;
               count_in    = '0;
            end
         end else if (count_ff == LAST_COUNT) begin
            in_frame_in = 1'b0;
            count_in    = '0;
         end else begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         in_frame_ff      <= 1'b0;
         count_ff         <= '0;
         rsp_valid_ff     <= 1'b0;
         reply_address_ff <= 8'd0;
         state_ff.node_address   <= NODE_ADDRESS_RST;
         state_ff.net_header     <= NET_HEADER_RST;
         state_ff.trigger_source <= TRIGGER_SOURCE_RST;
         state_ff.last_id        <= LAST_ID_RST;
         state_ff.lamp           <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         in_frame_ff  <= in_frame_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr.valid) begin
            reply_address_ff <= csr.reply_address;
         end
         if (fire) begin
            state_ff <= state_nxt;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_byte_ff <= req.rx_byte;
      end
      if (fire) begin
         rsp_data_ff <= result;
      end
      for (int i = 0; i < STORE_DEPTH; i++) begin
         if (store_wr && count_ff == CW'(i)) begin
            store_ff[i] <= in_byte_ff;
         end
      end
   end

   assign csr.ready = 1'b1;

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.action       = rsp_data_ff.action;
   assign rsp.lamp         = rsp_data_ff.lamp;
   assign rsp.reply_valid  = rsp_data_ff.reply_valid;
   assign rsp.reply_header = rsp_data_ff.reply_header;
   assign rsp.reply_id     = rsp_data_ff.reply_id;
   assign rsp.reply_from   = rsp_data_ff.reply_from;
   assign rsp.reply_to     = rsp_data_ff.reply_to;
   assign rsp.reply_extra  = rsp_data_ff.reply_extra;

endmodule
